// File: sv/wsps_pkg.sv
package wsps_pkg;

  // strip geometry
  localparam int LED_COUNT    = 8;
  localparam int BITS_PER_LED = 32;
  localparam int LED_AW       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int BIT_W        = $clog2(BITS_PER_LED);
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;

  // configuration reset values in ticks
  localparam logic [CFG_W-1:0] RST_ONE_HIGH  = CFG_W'(700 / 5);
  localparam logic [CFG_W-1:0] RST_ONE_LOW   = CFG_W'(800 / 5);
  localparam logic [CFG_W-1:0] RST_ZERO_HIGH = CFG_W'(350 / 5);
  localparam logic [CFG_W-1:0] RST_ZERO_LOW  = CFG_W'(600 / 5);
  localparam logic [CFG_W-1:0] RST_GAP       = CFG_W'(60000 / 5);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd4;

  // command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_SEND  = 2'd1,
    PH_TRAIL = 2'd2
  } phase_t;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  led_slot;
    logic [31:0] color_word;
  } in_item_t;

  typedef struct packed {
    logic       pin_level;
    logic [1:0] frame_phase;
    logic       frame_done;
  } out_item_t;

  // colour store write request
  typedef struct packed {
    logic              en;
    logic [LED_AW-1:0] addr;
    logic [31:0]       data;
  } store_wr_t;

endpackage

// File: sv/ws2812_pulse_serializer.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_stall    in_item  (cmd, led_slot, color_word)
// out       output     out_valid / out_stall  out_item (pin_level, frame_phase, frame_done)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// one transaction is taken every cycle while in_stall is low; its result is in the output
// register in the next cycle, or in the skid entry while out_stall holds that register.
// the colour store is read ahead, through its registered read port, at the LED the next tick needs,
// with write-first forwarding, so a tick never waits on the memory port.
// rst is synchronous; the store reads as zero until an entry is written.
// in_stall rises only when both the output register and its skid entry are full.
module ws2812_pulse_serializer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  wsps_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output wsps_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [wsps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsps_pkg::CFG_W-1:0]     cfg_data
);
  import wsps_pkg::*;

  logic              fire;
  store_wr_t         wr;
  logic [LED_AW-1:0] rd_addr;
  logic [31:0]       rd_data;
  out_item_t         result;
  logic              full;

  assign fire     = in_valid && !in_stall;
  assign in_stall = full;

  // colour store write
  assign wr.en   = fire && (in_item.cmd == CMD_WRITE);
  assign wr.addr = in_item.led_slot[LED_AW-1:0];
  assign wr.data = in_item.color_word;

  wsps_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wsps_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .cmd       (in_item.cmd),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .result    (result)
  );

  wsps_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_item (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // every accepted transaction produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  // skid entry fills only behind a held output
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // frame end reported only in the trailing gap
  a_done_in_trail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.frame_done) |-> (out_item.frame_phase == PH_TRAIL))
    else $error("frame_done outside trailing gap");

  // pin only goes high while sending bits
  a_pin_high_in_send: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.pin_level) |-> (out_item.frame_phase == PH_SEND))
    else $error("pin high outside send phase");

endmodule

// File: sv/wsps_store.sv
module wsps_store (
  input  logic                      clk,
  input  logic                      rst,
  input  wsps_pkg::store_wr_t       wr,
  input  logic [wsps_pkg::LED_AW-1:0] rd_addr,
  output logic [31:0]               rd_data
);
  import wsps_pkg::*;

  logic [31:0]          mem [LED_COUNT];
  logic [LED_COUNT-1:0] vld;

  // colour word array, no reset
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // written flags, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // registered read with write-first forwarding on the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_data <= '0;
    end else if (wr.en && (wr.addr == rd_addr)) begin
      rd_data <= wr.data;
    end else if (vld[rd_addr]) begin
      rd_data <= mem[rd_addr];
    end else begin
      rd_data <= '0;
    end
  end

endmodule

// File: sv/wsps_frame.sv
module wsps_frame (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [wsps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsps_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         fire,
  input  logic                         cmd,
  input  logic [31:0]                  rd_data,
  output logic [wsps_pkg::LED_AW-1:0]  rd_addr,
  output wsps_pkg::out_item_t          result
);
  import wsps_pkg::*;

  logic [CFG_W-1:0] one_high, one_low, zero_high, zero_low, gap;

  phase_t            phase, phase_next;
  logic [LED_AW-1:0] led, led_next;
  logic [BIT_W-1:0]  bit_cnt, bit_cnt_next;
  logic              high_half, high_half_next;
  logic [CFG_W-1:0]  tick_cnt, tick_cnt_next;
  logic              pin, pin_next;
  logic              held_bit, held_bit_next;
  logic              done;

  logic [CFG_W-1:0]  tick_inc;
  logic [CFG_W-1:0]  seg_len;
  logic              seg_end;
  logic              cur_bit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      one_high  <= RST_ONE_HIGH;
      one_low   <= RST_ONE_LOW;
      zero_high <= RST_ZERO_HIGH;
      zero_low  <= RST_ZERO_LOW;
      gap       <= RST_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ONE_HIGH:  one_high  <= cfg_data;
        CFG_ONE_LOW:   one_low   <= cfg_data;
        CFG_ZERO_HIGH: zero_high <= cfg_data;
        CFG_ZERO_LOW:  zero_low  <= cfg_data;
        CFG_GAP:       gap       <= cfg_data;
        default: ;
      endcase
    end
  end

  // bit value: sampled from the store on the first high tick, else held
  assign cur_bit = (high_half && (tick_cnt == '0)) ? rd_data[bit_cnt] : held_bit;

  // segment length for the current tick
  always_comb begin
    case (phase)
      PH_SEND: begin
        if (high_half) begin
          seg_len = cur_bit ? one_high : zero_high;
        end else begin
          seg_len = cur_bit ? one_low : zero_low;
        end
      end
      default: seg_len = gap;
    endcase
  end

  // tick counter end test, a zero length acts as one tick
  assign tick_inc = tick_cnt + CFG_W'(1);
  assign seg_end  = (tick_inc >= seg_len) || (tick_inc == '0);

  // frame sequencer
  always_comb begin
    phase_next     = phase;
    led_next       = led;
    bit_cnt_next   = bit_cnt;
    high_half_next = high_half;
    tick_cnt_next  = tick_cnt;
    pin_next       = pin;
    held_bit_next  = held_bit;
    done           = 1'b0;
    if (fire && (cmd == CMD_TICK)) begin
      tick_cnt_next = seg_end ? '0 : tick_inc;
      case (phase)
        PH_LEAD: begin
          pin_next = 1'b0;
          if (seg_end) begin
            phase_next     = PH_SEND;
            led_next       = '0;
            bit_cnt_next   = BIT_W'(BITS_PER_LED - 1);
            high_half_next = 1'b1;
          end
        end
        PH_SEND: begin
          held_bit_next = cur_bit;
          if (high_half) begin
            pin_next = 1'b1;
            if (seg_end) begin
              high_half_next = 1'b0;
            end
          end else begin
            pin_next = 1'b0;
            if (seg_end) begin
              high_half_next = 1'b1;
              if (bit_cnt == '0) begin
                if (led == LED_AW'(LED_COUNT - 1)) begin
                  phase_next = PH_TRAIL;
                end else begin
                  led_next     = led + LED_AW'(1);
                  bit_cnt_next = BIT_W'(BITS_PER_LED - 1);
                end
              end else begin
                bit_cnt_next = bit_cnt - BIT_W'(1);
              end
            end
          end
        end
        default: begin
          pin_next = 1'b0;
          if (seg_end) begin
            done           = 1'b1;
            phase_next     = PH_LEAD;
            led_next       = '0;
            bit_cnt_next   = BIT_W'(BITS_PER_LED - 1);
            high_half_next = 1'b0;
          end
        end
      endcase
    end
  end

  // prefetch the word of the LED that the next tick works on
  assign rd_addr = led_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      led       <= '0;
      bit_cnt   <= BIT_W'(BITS_PER_LED - 1);
      high_half <= 1'b0;
      tick_cnt  <= '0;
      pin       <= 1'b0;
      held_bit  <= 1'b0;
    end else begin
      phase     <= phase_next;
      led       <= led_next;
      bit_cnt   <= bit_cnt_next;
      high_half <= high_half_next;
      tick_cnt  <= tick_cnt_next;
      pin       <= pin_next;
      held_bit  <= held_bit_next;
    end
  end

  // result of this transaction: a write reports the held level
  assign result.pin_level   = pin_next;
  assign result.frame_phase = phase;
  assign result.frame_done  = done;

endmodule

// File: sv/wsps_skid.sv
module wsps_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wsps_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output wsps_pkg::out_item_t out_item
);
  import wsps_pkg::*;

  logic      skid_valid;
  out_item_t skid_item;
  logic      take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (push) begin
        out_item <= push_item;
      end
    end else if (push) begin
      skid_item <= push_item;
    end
  end

endmodule
